// ===== hdl/ngts_pkg.sv =====
// shared types and constants for the n-gram table text scorer
// no dependencies
package ngts_pkg;
    localparam int TableDepth = 4096;
    localparam int AddrW = $clog2(TableDepth);
    localparam int CountW = AddrW + 1;
    localparam int KeyW = 64;
    localparam int ValW = 24;
    localparam int SumW = 56;
    localparam int CntW = 32;
    localparam int MaxKeyBytes = 8;
    localparam int MinKeyBytes = 2;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_END   = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_ORDER   = 3'd2;
    localparam logic [2:0] ST_NOSCORE = 3'd3;
    localparam logic [2:0] ST_SCORE   = 3'd4;
    localparam logic [2:0] ST_BYTE    = 3'd5;

    localparam logic CFG_KEY_LENGTH = 1'b0;
    localparam logic CFG_UNSEEN     = 1'b1;

    typedef struct packed {
        logic [1:0]      op;
        logic [KeyW-1:0] key;
        logic [ValW-1:0] value;
        logic [7:0]      text_byte;
    } cmd_t;

    function automatic logic [KeyW-1:0] key_mask(input logic [3:0] n);
        logic [KeyW-1:0] m;
        m = '0;
        for (int i = 0; i < MaxKeyBytes; i++) begin
            if (i < n) m[i*8 +: 8] = 8'hff;
        end
        return m;
    endfunction

    function automatic logic [3:0] eff_len(input logic [3:0] k);
        if (k < 4'(MinKeyBytes)) return 4'(MinKeyBytes);
        if (k > 4'(MaxKeyBytes)) return 4'(MaxKeyBytes);
        return k;
    endfunction
endpackage

// ===== hdl/ngts_front.sv =====
// front part: input handshake, masks and lowercases, and writes items to a short queue
// depends on ngts_pkg
module ngts_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_opcode,
    input  logic [63:0]       s_entry_key,
    input  logic [23:0]       s_entry_value,
    input  logic [7:0]        s_text_byte,
    input  logic [3:0]        key_len,
    output ngts_pkg::cmd_t    q_data,
    output logic              q_valid,
    input  logic              q_pop
);
    ngts_pkg::cmd_t mem_reg [2];
    logic [1:0] wp_reg, rp_reg, wp_next, rp_next;
    ngts_pkg::cmd_t c;
    logic push;

    assign s_ready = (wp_reg - rp_reg) != 2'd2;
    assign push = s_valid && s_ready;
    assign q_valid = wp_reg != rp_reg;
    assign q_data = mem_reg[rp_reg[0]];
    assign wp_next = wp_reg + 2'(push);
    assign rp_next = rp_reg + 2'(q_pop);

    always_comb begin
        c.op = s_opcode;
        c.key = s_entry_key & ngts_pkg::key_mask(ngts_pkg::eff_len(key_len));
        c.value = s_entry_value;
        // ascii uppercase folds to lowercase
        c.text_byte = (s_text_byte >= 8'h41 && s_text_byte <= 8'h5a) ?
                      s_text_byte + 8'd32 : s_text_byte;
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg[0]] <= c;
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
        end else begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
        end
    end
endmodule

// ===== hdl/ngts_div.sv =====
// signed 56 by 32 bit restoring divider, one quotient bit per cycle
// depends on ngts_pkg
module ngts_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic signed [ngts_pkg::SumW-1:0] dividend,
    input  logic [ngts_pkg::CntW-1:0]     divisor,
    output logic                          done,
    output logic [ngts_pkg::ValW-1:0]     quotient
);
    localparam int W = ngts_pkg::SumW;
    logic [W-1:0] q_reg, q_next;
    logic [ngts_pkg::CntW:0] r_reg, r_next;
    logic [ngts_pkg::CntW-1:0] d_reg;
    logic neg_reg, busy_reg, busy_next;
    logic [5:0] cnt_reg, cnt_next;
    logic [ngts_pkg::CntW:0] trial;
    logic [W-1:0] qneg;

    always_comb begin
        trial = {r_reg[ngts_pkg::CntW-1:0], q_reg[W-1]} - {1'b0, d_reg};
        q_next = q_reg;
        r_next = r_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        if (busy_reg) begin
            if (!trial[ngts_pkg::CntW]) begin
                r_next = trial;
                q_next = {q_reg[W-2:0], 1'b1};
            end else begin
                r_next = {r_reg[ngts_pkg::CntW-1:0], q_reg[W-1]};
                q_next = {q_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) busy_next = 1'b0;
        end
        qneg = neg_reg ? (~q_reg + 1'b1) : q_reg;
    end

    assign quotient = qneg[ngts_pkg::ValW-1:0];

    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg <= dividend[W-1];
            q_reg <= dividend[W-1] ? W'(-dividend) : W'(dividend);
            r_reg <= '0;
            d_reg <= divisor;
            cnt_reg <= 6'(W);
        end else begin
            q_reg <= q_next;
            r_reg <= r_next;
            cnt_reg <= cnt_next;
        end
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done <= 1'b0;
        end else begin
            busy_reg <= start ? 1'b1 : busy_next;
            done <= busy_reg && !busy_next && !start;
        end
    end
endmodule

// ===== hdl/ngts_back.sv =====
// back part: table memory, binary search, score accumulation and result register
// depends on ngts_pkg and ngts_div
module ngts_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  ngts_pkg::cmd_t    q_data,
    input  logic              q_valid,
    output logic              q_pop,
    input  logic [3:0]        key_len,
    input  logic [23:0]       unseen,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [2:0]        m_status,
    output logic [23:0]       m_mean_score,
    output logic [31:0]       m_window_total
);
    localparam int AW = ngts_pkg::AddrW;
    localparam int CW = ngts_pkg::CountW;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_LAST  = 7'b0000010,
        S_PROBE = 7'b0000100,
        S_CMP   = 7'b0001000,
        S_VAL   = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t state_reg;
    logic [ngts_pkg::KeyW-1:0] keys_mem [ngts_pkg::TableDepth];
    logic [ngts_pkg::ValW-1:0] vals_mem [ngts_pkg::TableDepth];
    logic [ngts_pkg::KeyW-1:0] rkey_reg;
    logic [ngts_pkg::ValW-1:0] rval_reg;
    logic [AW-1:0] raddr;
    logic rd_en;

    logic [CW-1:0] count_reg;
    logic [63:0] win_reg;
    logic [3:0] seen_reg;
    logic signed [ngts_pkg::SumW-1:0] sum_reg;
    logic [31:0] wcnt_reg;
    logic [CW-1:0] lo_reg, hi_reg;
    logic [ngts_pkg::KeyW-1:0] skey_reg;
    ngts_pkg::cmd_t cmd_reg;
    logic [CW-1:0] mid;
    logic div_start, div_done;
    logic [ngts_pkg::ValW-1:0] div_q;
    logic [3:0] n;
    logic [3:0] seen_inc;
    logic res_load;

    assign n = ngts_pkg::eff_len(key_len);
    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign seen_inc = (seen_reg < 4'(ngts_pkg::MaxKeyBytes)) ? seen_reg + 4'd1 : seen_reg;

    ngts_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(sum_reg), .divisor(wcnt_reg), .done(div_done), .quotient(div_q)
    );

    assign q_pop = (state_reg == S_IDLE) && q_valid;
    // one start pulse, on the cycle the end item is marked for division
    assign div_start = (state_reg == S_DIV) && (cmd_reg.op == ngts_pkg::OP_END)
                       && seen_reg != 4'hf && count_reg != '0 && wcnt_reg != '0;
    assign res_load = (state_reg == S_CMP && !m_valid)
                      || (state_reg == S_OUT && (!m_valid || m_ready));

    always_comb begin
        raddr = (state_reg == S_LAST) ? AW'(count_reg - CW'(1)) : mid[AW-1:0];
        rd_en = (state_reg == S_LAST) || (state_reg == S_PROBE);
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rkey_reg <= keys_mem[raddr];
            rval_reg <= vals_mem[raddr];
        end
        if (state_reg == S_CMP && cmd_reg.op == ngts_pkg::OP_LOAD
            && count_reg < CW'(ngts_pkg::TableDepth)
            && !(count_reg != '0 && cmd_reg.key < rkey_reg)) begin
            keys_mem[count_reg[AW-1:0]] <= cmd_reg.key;
            vals_mem[count_reg[AW-1:0]] <= cmd_reg.value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            win_reg <= '0;
            seen_reg <= '0;
            sum_reg <= '0;
            wcnt_reg <= '0;
            m_valid <= 1'b0;
        end else begin
            if (res_load) m_valid <= 1'b1;
            else if (m_ready) m_valid <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        cmd_reg <= q_data;
                        case (q_data.op)
                            ngts_pkg::OP_LOAD: state_reg <= S_LAST;
                            ngts_pkg::OP_BYTE: state_reg <= S_PROBE;
                            default: state_reg <= S_DIV;
                        endcase
                        lo_reg <= '0;
                        hi_reg <= count_reg;
                        if (q_data.op == ngts_pkg::OP_BYTE) begin
                            win_reg <= {win_reg[55:0], q_data.text_byte};
                            seen_reg <= seen_inc;
                            skey_reg <= {win_reg[55:0], q_data.text_byte}
                                        & ngts_pkg::key_mask(n);
                        end
                    end
                end
                S_LAST: state_reg <= S_CMP;
                S_CMP: begin
                    // load: check fullness and order against last entry; defer to S_OUT while a result is held
                    if (!m_valid) begin
                        m_mean_score <= '0;
                        m_window_total <= '0;
                        if (count_reg >= CW'(ngts_pkg::TableDepth)) begin
                            m_status <= ngts_pkg::ST_FULL;
                        end else if (count_reg != '0 && cmd_reg.key < rkey_reg) begin
                            m_status <= ngts_pkg::ST_ORDER;
                        end else begin
                            m_status <= ngts_pkg::ST_OK;
                            count_reg <= count_reg + CW'(1);
                        end
                        state_reg <= S_IDLE;
                    end else begin
                        state_reg <= S_OUT;
                    end
                end
                S_PROBE: begin
                    // search step issue; skip when no full window or saturated, add unseen when range is empty
                    if (seen_reg < n || wcnt_reg == '1) begin
                        state_reg <= S_OUT;
                    end else if (lo_reg >= hi_reg) begin
                        sum_reg <= sum_reg + ngts_pkg::SumW'(signed'(unseen));
                        wcnt_reg <= wcnt_reg + 32'd1;
                        state_reg <= S_OUT;
                    end else begin
                        state_reg <= S_VAL;
                    end
                end
                S_VAL: begin
                    if (rkey_reg < skey_reg) begin
                        lo_reg <= mid + CW'(1);
                        state_reg <= S_PROBE;
                    end else if (rkey_reg > skey_reg) begin
                        hi_reg <= mid;
                        state_reg <= S_PROBE;
                    end else begin
                        sum_reg <= sum_reg + ngts_pkg::SumW'(signed'(rval_reg));
                        wcnt_reg <= wcnt_reg + 32'd1;
                        state_reg <= S_OUT;
                    end
                end
                S_DIV: begin
                    if (cmd_reg.op == ngts_pkg::OP_CLEAR) begin
                        count_reg <= '0;
                        state_reg <= S_OUT;
                    end else if (seen_reg != 4'hf) begin
                        if (count_reg == '0 || wcnt_reg == '0) begin
                            state_reg <= S_OUT;
                        end else begin
                            seen_reg <= 4'hf;
                        end
                    end else if (div_done) begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!m_valid || m_ready) begin
                        state_reg <= S_IDLE;
                        case (cmd_reg.op)
                            ngts_pkg::OP_LOAD: begin
                                // stalled load result recomputed
                                m_mean_score <= '0;
                                m_window_total <= '0;
                                if (count_reg >= CW'(ngts_pkg::TableDepth)) begin
                                    m_status <= ngts_pkg::ST_FULL;
                                end else if (count_reg != '0 && cmd_reg.key < rkey_reg) begin
                                    m_status <= ngts_pkg::ST_ORDER;
                                end else begin
                                    m_status <= ngts_pkg::ST_OK;
                                    count_reg <= count_reg + CW'(1);
                                end
                            end
                            ngts_pkg::OP_BYTE: begin
                                m_status <= ngts_pkg::ST_BYTE;
                                m_mean_score <= '0;
                                m_window_total <= wcnt_reg;
                            end
                            ngts_pkg::OP_END: begin
                                m_window_total <= wcnt_reg;
                                if (seen_reg == 4'hf) begin
                                    m_status <= ngts_pkg::ST_SCORE;
                                    m_mean_score <= div_q;
                                end else begin
                                    m_status <= ngts_pkg::ST_NOSCORE;
                                    m_mean_score <= '0;
                                end
                                win_reg <= '0;
                                seen_reg <= '0;
                                sum_reg <= '0;
                                wcnt_reg <= '0;
                            end
                            default: begin
                                m_status <= ngts_pkg::ST_OK;
                                m_mean_score <= '0;
                                m_window_total <= '0;
                            end
                        endcase
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== hdl/ngram_table_text_scorer_core.sv =====
// Top level of the n-gram table text scorer.
// Input channel s_*: opcode 0 loads an entry, 1 scores a text byte, 2 ends a text, 3 clears.
// Config channel cfg_*: index 0 key_length, 1 unseen_value, always ready.
// Result channel m_*: one result per input transfer, in order.
// A two-entry queue separates the input side from the execution engine.
// Path from input transfer to result: a load reads the last entry and then checks it; a clear
// goes through S_DIV and S_OUT. A text byte without a full window goes straight to S_OUT;
// otherwise each binary-search probe issues a registered table memory read and then compares,
// ending when the key is found or the range is empty: up to 13 probes at 4096 entries.
// End of text goes to S_OUT directly without a score, and with one waits for the
// bit-serial divider to work through all 56 dividend bits.
// Items are carried out one at a time; the next queued item starts the cycle after a
// result is written.
// Reset clears the table count, the text state, the queue, m_valid and the config registers to
// their defaults; table memory contents and the result data fields are left as they are.
// A stalled receiver holds the result register; the queue keeps taking up to two
// more items before s_ready drops.
// Depends on ngts_pkg, ngts_front, ngts_back, ngts_div.
module ngram_table_text_scorer_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [63:0] s_entry_key,
    input  logic [23:0] s_entry_value,
    input  logic [7:0]  s_text_byte,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [23:0] cfg_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [23:0] m_mean_score,
    output logic [31:0] m_window_total
);
    logic [3:0] key_len_reg;
    logic [23:0] unseen_reg;
    ngts_pkg::cmd_t q_data;
    logic q_valid, q_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_len_reg <= 4'd3;
            unseen_reg <= 24'hf60000;
        end else if (cfg_valid) begin
            case (cfg_index)
                ngts_pkg::CFG_KEY_LENGTH: key_len_reg <= cfg_data[3:0];
                ngts_pkg::CFG_UNSEEN: unseen_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    ngts_front u_front (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_opcode(s_opcode), .s_entry_key(s_entry_key), .s_entry_value(s_entry_value),
        .s_text_byte(s_text_byte), .key_len(key_len_reg),
        .q_data(q_data), .q_valid(q_valid), .q_pop(q_pop)
    );

    ngts_back u_back (
        .aclk(aclk), .aresetn(aresetn), .q_data(q_data), .q_valid(q_valid), .q_pop(q_pop),
        .key_len(key_len_reg), .unseen(unseen_reg),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_mean_score(m_mean_score), .m_window_total(m_window_total)
    );
endmodule

// ===== hdl/ngts_checker.sv =====
// port-level checks for the n-gram table text scorer
// depends on ngts_pkg and the ngram_table_text_scorer_core ports only
module ngts_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_status,
    input logic [23:0] m_mean_score,
    input logic [31:0] m_window_total
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status))
        else $error("result dropped while stalled");
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status <= ngts_pkg::ST_BYTE)
        else $error("bad status code");
    a_mean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ngts_pkg::ST_SCORE |-> m_mean_score == 24'd0)
        else $error("mean without score");
    a_tot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status <= ngts_pkg::ST_ORDER |-> m_window_total == 32'd0)
        else $error("total on table op");
endmodule

bind ngram_table_text_scorer_core ngts_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .m_valid(m_valid), .m_ready(m_ready),
    .m_status(m_status), .m_mean_score(m_mean_score), .m_window_total(m_window_total)
);

// ===== tb/ngram_table_text_scorer_core_test.sv =====
// testbench for ngram_table_text_scorer_core: loads sorted n-gram tables, streams text
// and checks every status, mean and window count against a predictor in the class below
// depends on ngts_pkg and the scorer rtl
module ngram_table_text_scorer_core_test;
    typedef struct {
        logic [2:0]  status;
        logic [23:0] mean_score;
        logic [31:0] window_total;
    } score_result_t;

    class text_score_tracker;
        logic [63:0]    keys [ngts_pkg::TableDepth];
        logic [23:0]    values [ngts_pkg::TableDepth];
        int unsigned    entries;
        logic [63:0]    window;
        int unsigned    seen;
        longint         sum;
        longint         windows;
        logic [3:0]     key_len;
        logic [23:0]    unseen;
        score_result_t  expected_results [$];
        int             errors;

        function new();
            entries = 0;
            window = '0;
            seen = 0;
            sum = 0;
            windows = 0;
            key_len = 4'd3;
            unseen = -24'sd655360;
            errors = 0;
        endfunction

        function int unsigned eff();
            if (key_len < 2) return 2;
            if (key_len > 8) return 8;
            return 32'(key_len);
        endfunction

        function logic [63:0] mask_for(int unsigned n);
            if (n >= 8) return '1;
            return (64'h1 << (n * 8)) - 1;
        endfunction

        function void write_reg(logic idx, logic [23:0] data);
            if (idx == ngts_pkg::CFG_KEY_LENGTH) key_len = data[3:0];
            else unseen = data;
        endfunction

        function logic [23:0] lookup(logic [63:0] key);
            int unsigned lo, hi, mid;
            lo = 0;
            hi = entries;
            while (lo < hi) begin
                mid = lo + (hi - lo) / 2;
                if (keys[mid] < key) lo = mid + 1;
                else if (keys[mid] > key) hi = mid;
                else return values[mid];
            end
            return unseen;
        endfunction

        function void note_item(logic [1:0] op, logic [63:0] key, logic [23:0] val,
                                logic [7:0] b);
            score_result_t r;
            int unsigned n;
            logic [63:0] k;
            longint q;
            n = eff();
            r.status = ngts_pkg::ST_OK;
            r.mean_score = '0;
            r.window_total = '0;
            case (op)
                ngts_pkg::OP_LOAD: begin
                    k = key & mask_for(n);
                    if (entries >= ngts_pkg::TableDepth) r.status = ngts_pkg::ST_FULL;
                    else if (entries > 0 && k < keys[entries-1]) r.status = ngts_pkg::ST_ORDER;
                    else begin
                        keys[entries] = k;
                        values[entries] = val;
                        entries++;
                    end
                end
                ngts_pkg::OP_BYTE: begin
                    if (b >= "A" && b <= "Z") b = b + 8'd32;
                    window = {window[55:0], b};
                    if (seen < 8) seen++;
                    if (seen >= n && windows < 64'hffff_ffff) begin
                        sum += longint'($signed(lookup(window & mask_for(n))));
                        windows++;
                    end
                    r.status = ngts_pkg::ST_BYTE;
                    r.window_total = windows[31:0];
                end
                ngts_pkg::OP_END: begin
                    r.window_total = windows[31:0];
                    if (entries == 0 || windows == 0) r.status = ngts_pkg::ST_NOSCORE;
                    else begin
                        q = sum / windows;
                        r.mean_score = q[23:0];
                        r.status = ngts_pkg::ST_SCORE;
                    end
                    window = '0;
                    seen = 0;
                    sum = 0;
                    windows = 0;
                end
                default: entries = 0;
            endcase
            expected_results = {expected_results, r};
        endfunction

        function void check_result(logic [2:0] st, logic [23:0] mean, logic [31:0] tot);
            score_result_t r;
            if (expected_results.size() == 0) begin
                $error("unexpected result transfer: status %0d", st);
                errors++;
                return;
            end
            r = expected_results.pop_front();
            if (st !== r.status) begin
                $error("status: expected %0d, got %0d", r.status, st);
                errors++;
            end
            if (mean !== r.mean_score) begin
                $error("mean_score: expected %0d, got %0d", $signed(r.mean_score),
                       $signed(mean));
                errors++;
            end
            if (tot !== r.window_total) begin
                $error("window_total: expected %0d, got %0d", r.window_total, tot);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_opcode = '0;
    logic [63:0] s_entry_key = '0;
    logic [23:0] s_entry_value = '0;
    logic [7:0]  s_text_byte = '0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [23:0] cfg_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_status;
    logic [23:0] m_mean_score;
    logic [31:0] m_window_total;

    text_score_tracker book = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;

    ngram_table_text_scorer_core dut (.*);

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            book.check_result(m_status, m_mean_score, m_window_total);
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        #(8 * 4_000_000);
        $display("ngram_table_text_scorer_core: mismatch");
        $finish;
    end

    task automatic send_item(logic [1:0] op, logic [63:0] key, logic [23:0] val,
                             logic [7:0] b);
        int gap;
        if ($urandom_range(99) < send_idle_pct) begin
            gap = $urandom_range(1, 4);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_opcode <= op;
        s_entry_key <= key;
        s_entry_value <= val;
        s_text_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        book.note_item(op, key, val, b);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (book.expected_results.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [23:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        book.write_reg(idx, data);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_item(ngts_pkg::OP_BYTE, '0, '0, s[i]);
    endtask

    function automatic logic [7:0] letter();
        logic [7:0] c;
        c = 8'("a") + 8'($urandom_range(2));
        if ($urandom_range(3) == 0) c = c - 8'd32;
        return c;
    endfunction

    // one text over a sorted table, cleared first when restart is set, with some noise and broken loads
    task automatic text_phase(int nload, int nbytes, bit restart, bit finish_text);
        logic [63:0] key_list [$];
        logic [63:0] k, t;
        int unsigned n;
        n = book.eff();
        for (int i = 0; i < nload; i++) begin
            k = '0;
            for (int j = 0; j < n; j++) k = {k[55:0], 8'("a") + 8'($urandom_range(2))};
            key_list = {key_list, k};
        end
        key_list.sort();
        if (nload > 2 && $urandom_range(3) == 0) begin
            t = key_list[0];
            key_list[0] = key_list[nload-1];
            key_list[nload-1] = t;
        end
        if (restart)
            send_item(ngts_pkg::OP_CLEAR, {$urandom, $urandom}, 24'($urandom),
                      8'($urandom));
        foreach (key_list[i]) begin
            k = key_list[i];
            // garbage above the key length must be masked
            if ($urandom_range(4) == 0) k = k | ({$urandom, $urandom} & ~book.mask_for(n));
            send_item(ngts_pkg::OP_LOAD, k, 24'($urandom), 8'($urandom));
        end
        for (int i = 0; i < nbytes; i++) begin
            if ($urandom_range(19) == 0)
                send_item(2'($urandom_range(3)), {$urandom, $urandom}, 24'($urandom),
                          8'($urandom));
            else if ($urandom_range(9) == 0)
                send_item(ngts_pkg::OP_BYTE, {$urandom, $urandom}, 24'($urandom),
                          8'($urandom_range(255)));
            else
                send_item(ngts_pkg::OP_BYTE, {$urandom, $urandom}, 24'($urandom), letter());
        end
        if (finish_text)
            send_item(ngts_pkg::OP_END, {$urandom, $urandom}, 24'($urandom), 8'($urandom));
    endtask

    initial begin
        logic [3:0] lengths [10];
        logic [23:0] unseen_pick;
        lengths = '{4'd3, 4'd2, 4'd8, 4'd0, 4'd1, 4'd9, 4'd15, 4'd5, 4'd4, 4'd2};
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, ordering, lowercase folding, empty cases
        send_item(ngts_pkg::OP_END, '0, '0, '0);
        send_item(ngts_pkg::OP_LOAD, 64'hffff_ffff_ff61_6263, 24'h7fffff, 8'hff);
        send_item(ngts_pkg::OP_LOAD, 64'h0000_0000_0061_6264, 24'h800000, '0);
        send_item(ngts_pkg::OP_LOAD, 64'h0000_0000_0061_6161, 24'h000001, '0);
        send_item(ngts_pkg::OP_LOAD, 64'h0000_0000_0061_6264, 24'hffffff, '0);
        send_item(ngts_pkg::OP_LOAD, 64'h0000_0000_0062_6262, 24'h123456, '0);
        send_text("ABCd");
        send_item(ngts_pkg::OP_BYTE, '1, '1, 8'h00);
        send_item(ngts_pkg::OP_BYTE, '0, '0, 8'hff);
        send_text("Z@[abd");
        send_item(ngts_pkg::OP_END, '1, '1, '1);
        send_text("ab");
        send_item(ngts_pkg::OP_END, '0, '0, '0);
        send_item(ngts_pkg::OP_CLEAR, '1, '1, '1);
        send_text("abcd");
        send_item(ngts_pkg::OP_END, '0, '0, '0);
        drain();
        write_reg(ngts_pkg::CFG_UNSEEN, 24'h800000);
        send_text("xyzw");
        send_item(ngts_pkg::OP_END, '0, '0, '0);
        drain();

        for (int p = 0; p < 12; p++) begin
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            write_reg(ngts_pkg::CFG_KEY_LENGTH,
                      {20'($urandom_range(24'hfffff)), lengths[p % 10]});
            case ($urandom_range(3))
                0: unseen_pick = 24'h800000;
                1: unseen_pick = 24'h7fffff;
                default: unseen_pick = 24'($urandom);
            endcase
            write_reg(ngts_pkg::CFG_UNSEEN, unseen_pick);
            if (p == 5) begin
                hold_cycles = 300;
                send_idle_pct = 0;
            end
            // some phases leave the text open so a new key length applies mid-text
            text_phase($urandom_range(0, 12), $urandom_range(10, 24), p % 3 != 2,
                       p % 4 != 3);
            if (p == 7) begin
                s_valid <= 1'b0;
                while (book.expected_results.size() != 0) @(posedge aclk);
                text_phase(3, 6, 1'b0, 1'b1);
            end
            drain();
        end

        // a longer sorted table for deeper searches
        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_reg(ngts_pkg::CFG_KEY_LENGTH, 24'd2);
        send_item(ngts_pkg::OP_CLEAR, '0, '0, '0);
        for (int i = 0; i < 48; i++)
            send_item(ngts_pkg::OP_LOAD, 64'(i * 16), 24'($urandom), '0);
        send_item(ngts_pkg::OP_LOAD, 64'hffff, 24'($urandom), '0);
        send_item(ngts_pkg::OP_LOAD, 64'h0, 24'($urandom), '0);
        for (int i = 0; i < 30; i++)
            send_item(ngts_pkg::OP_BYTE, '0, '0, 8'($urandom_range(255)));
        send_item(ngts_pkg::OP_END, '0, '0, '0);
        drain();

        if (book.errors == 0) $display("ngram_table_text_scorer_core: match");
        else $display("ngram_table_text_scorer_core: mismatch");
        $finish;
    end
endmodule
